// File: rtl/c8core_pkg.sv
`timescale 1ns / 1ps
package c8core_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int ROW_W       = $clog2(SCR_H);
  localparam int COL_W       = $clog2(SCR_W);
  localparam int FONT_BYTES  = 80;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_ROW   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_WAIT_KEY   = 2'd1,
    ST_ILLEGAL    = 2'd2,
    ST_WAIT_FRAME = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ALU_PASSB, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FH, S_FL, S_RDY, S_EXEC, S_ROW, S_CLS,
    S_DRA, S_DRB, S_BCD, S_ST, S_LDA, S_LDB, S_RESP
  } state_t;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  KK_SKP  = 8'h9E;
  localparam logic [7:0]  KK_SKNP = 8'hA1;
  localparam logic [7:0]  KK_LDDT = 8'h07;
  localparam logic [7:0]  KK_WKEY = 8'h0A;
  localparam logic [7:0]  KK_SDT  = 8'h15;
  localparam logic [7:0]  KK_SST  = 8'h18;
  localparam logic [7:0]  KK_ADDI = 8'h1E;
  localparam logic [7:0]  KK_FONT = 8'h29;
  localparam logic [7:0]  KK_BCD  = 8'h33;
  localparam logic [7:0]  KK_DUMP = 8'h55;
  localparam logic [7:0]  KK_FILL = 8'h65;
  localparam logic [ADDR_W-1:0] RESET_PC = 12'h200;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] pc;
    logic [15:0]       opcode;
    logic [SCR_W-1:0]  row;
    logic              sound;
  } c8_result_t;

  localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] b;
    b = 8'd0;
    if (a < ADDR_W'(FONT_BYTES)) b = GLYPHS[a[6:0]];
    return b;
  endfunction

endpackage

// File: rtl/c8core_mem.sv
`timescale 1ns / 1ps
module c8core_mem
  import c8core_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/c8core_alu.sv
`timescale 1ns / 1ps
module c8core_alu
  import c8core_pkg::*;
(
  input  alu_op_t    op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] res,
  output logic       flag
);

  logic [8:0] sum;
  logic [8:0] dif;

  assign sum = {1'b0, a} + {1'b0, b};
  assign dif = {1'b0, a} - {1'b0, b};

  always_comb begin
    res  = b;
    flag = 1'b0;
    case (op)
      ALU_PASSB: res = b;
      ALU_OR:    res = a | b;
      ALU_AND:   res = a & b;
      ALU_XOR:   res = a ^ b;
      ALU_ADD: begin
        res  = sum[7:0];
        flag = sum[8];
      end
      ALU_SUB: begin
        res  = dif[7:0];
        flag = ~dif[8];
      end
      ALU_SHR: begin
        res  = {1'b0, b[7:1]};
        flag = b[0];
      end
      ALU_SHL: begin
        res  = {b[6:0], 1'b0};
        flag = b[7];
      end
      default: res = b;
    endcase
  end

endmodule

// File: rtl/c8core_ctrl.sv
`timescale 1ns / 1ps
module c8core_ctrl
  import c8core_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cmd_t              cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       keys,
  input  logic [7:0]        random_byte,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_pc,
  output logic              ready,
  output logic              done,
  output c8_result_t        res
);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt, i_r, i_nxt, cnt_r, cnt_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt, st_r, st_nxt, vx_r, vx_nxt, vy_r, vy_nxt, rnd_r, rnd_nxt;
  logic [15:0] kn_r, kn_nxt, kb_r, kb_nxt, op_r, op_nxt;
  logic        drawn_r, drawn_nxt, hit_r, hit_nxt;
  status_t     status_r, status_nxt;
  logic [SCR_W-1:0]  row_r, row_nxt;
  logic [7:0]        v_r [16];
  logic [7:0]        v_nxt [16];
  logic [ADDR_W-1:0] stk_r [STACK_DEPTH];
  logic [ADDR_W-1:0] stk_nxt [STACK_DEPTH];

  // memory and screen ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              scr_we;
  logic [ROW_W-1:0]  scr_waddr, scr_raddr;
  logic [SCR_W-1:0]  scr_wdata, scr_rdata_r;
  logic [SCR_W-1:0]  scr_mem [SCR_H];

  alu_op_t    alu_op;
  logic [7:0] alu_a, alu_b, alu_res;
  logic       alu_flag;

  c8core_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  c8core_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_rdata_r <= scr_mem[scr_raddr];
  end

  // decode fields
  logic [3:0]  fx, fy, fn;
  logic [7:0]  kk;
  logic [ADDR_W-1:0] nnn;
  assign fx  = op_r[11:8];
  assign fy  = op_r[7:4];
  assign fn  = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[ADDR_W-1:0];

  // BCD digits by compare and reciprocal multiply
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tprod;
  logic [3:0]  tens, ones;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (vx_r >= 8'd200) hund = 2'd2;
    else if (vx_r >= 8'd100) hund = 2'd1;
    else hund = 2'd0;
    rem   = 7'(vx_r - (hund == 2'd2 ? 8'd200 : (hund == 2'd1 ? 8'd100 : 8'd0)));
    tprod = 15'(rem) * 15'd205;
    tens  = tprod[14:11];
    ones  = 4'(rem - 7'(tens) * 7'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'd0, hund};
      2'd1:    bcd_digit = {4'd0, tens};
      default: bcd_digit = {4'd0, ones};
    endcase
  end

  // lowest released key
  logic [15:0] released;
  logic        rel_any;
  logic [3:0]  rel_idx;
  always_comb begin
    released = kb_r & ~kn_r;
    rel_any  = |released;
    rel_idx  = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (released[k]) rel_idx = 4'(k);
    end
  end

  logic [ROW_W:0]   draw_row;
  logic [SCR_W-1:0] draw_mask;
  assign draw_row  = {1'b0, vy_r[ROW_W-1:0]} + {2'b0, cnt_r[3:0]};
  assign draw_mask = {mem_rdata, {(SCR_W-8){1'b0}}} >> vx_r[COL_W-1:0];

  logic key_down;
  assign key_down = kn_r[vx_r[3:0]];

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    sp_nxt     = sp_r;
    dt_nxt     = dt_r;
    st_nxt     = st_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    rnd_nxt    = rnd_r;
    kn_nxt     = kn_r;
    kb_nxt     = kb_r;
    op_nxt     = op_r;
    drawn_nxt  = drawn_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    row_nxt    = row_r;
    v_nxt      = v_r;
    stk_nxt    = stk_r;
    mem_we     = 1'b0;
    mem_waddr  = i_r;
    mem_wdata  = 8'd0;
    mem_raddr  = pc_r;
    scr_we     = 1'b0;
    scr_waddr  = cnt_r[ROW_W-1:0];
    scr_wdata  = '0;
    scr_raddr  = address[ROW_W-1:0];
    alu_op     = ALU_SUB;
    alu_a      = vx_r;
    alu_b      = vy_r;
    done       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = font_byte(cnt_r);
        scr_we    = 1'b1;
        if (cnt_r == ADDR_W'(MEM_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt     = '0;
          row_nxt    = '0;
          status_nxt = ST_DONE;
          rnd_nxt    = random_byte;
          state_nxt  = S_RESP;
          unique case (cmd)
            CMD_EXEC: begin
              if (drawn_r) status_nxt = ST_WAIT_FRAME;
              else state_nxt = S_FH;
            end
            CMD_FRAME: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 1'b1;
              if (st_r != 8'd0) st_nxt = st_r - 1'b1;
              drawn_nxt = 1'b0;
              kb_nxt    = kn_r;
              kn_nxt    = keys;
            end
            CMD_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = address;
              mem_wdata = data_byte;
            end
            CMD_ROW: state_nxt = S_ROW;
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_FH: begin
        op_nxt[15:8] = mem_rdata;
        mem_raddr    = pc_r + 1'b1;
        state_nxt    = S_FL;
      end
      S_FL: begin
        op_nxt[7:0] = mem_rdata;
        pc_nxt      = pc_r + ADDR_W'(2);
        vx_nxt      = v_r[op_r[11:8]];
        state_nxt   = S_RDY;
      end
      S_RDY: begin
        vy_nxt    = v_r[fy];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        cnt_nxt   = '0;
        unique case (op_r[15:12])
          4'h0: begin
            if (op_r == OP_CLS) begin
              state_nxt = S_CLS;
            end else if (op_r == OP_RET) begin
              pc_nxt = stk_r[sp_r];
              sp_nxt = sp_r - 1'b1;
            end else begin
              pc_nxt = nnn;
            end
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            sp_nxt = sp_r + 1'b1;
            stk_nxt[SP_W'(sp_r + 1'b1)] = pc_r;
            pc_nxt = nnn;
          end
          4'h3: begin
            alu_b = kk;
            if (alu_res == 8'd0) pc_nxt = pc_r + ADDR_W'(2);
          end
          4'h4: begin
            alu_b = kk;
            if (alu_res != 8'd0) pc_nxt = pc_r + ADDR_W'(2);
          end
          4'h5, 4'h9: begin
            if (fn != 4'h0) begin
              status_nxt = ST_ILLEGAL;
              pc_nxt     = pc_r - ADDR_W'(2);
            end else if ((alu_res == 8'd0) == (op_r[15:12] == 4'h5)) begin
              pc_nxt = pc_r + ADDR_W'(2);
            end
          end
          4'h6: v_nxt[fx] = kk;
          4'h7: begin
            alu_op    = ALU_ADD;
            alu_b     = kk;
            v_nxt[fx] = alu_res;
          end
          4'h8: begin
            case (fn)
              4'h0: alu_op = ALU_PASSB;
              4'h1: alu_op = ALU_OR;
              4'h2: alu_op = ALU_AND;
              4'h3: alu_op = ALU_XOR;
              4'h4: alu_op = ALU_ADD;
              4'h5: alu_op = ALU_SUB;
              4'h6: alu_op = ALU_SHR;
              4'h7: begin
                alu_op = ALU_SUB;
                alu_a  = vy_r;
                alu_b  = vx_r;
              end
              4'hE: alu_op = ALU_SHL;
              default: alu_op = ALU_PASSB;
            endcase
            if (fn inside {4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
              v_nxt[fx] = alu_res;
              if (fn != 4'h0) v_nxt[15] = {7'd0, alu_flag};
            end else begin
              status_nxt = ST_ILLEGAL;
              pc_nxt     = pc_r - ADDR_W'(2);
            end
          end
          4'hA: i_nxt = nnn;
          4'hB: pc_nxt = nnn + ADDR_W'(v_r[0]);
          4'hC: v_nxt[fx] = rnd_r & kk;
          4'hD: begin
            hit_nxt   = 1'b0;
            state_nxt = S_DRA;
          end
          4'hE: begin
            if (kk == KK_SKP) begin
              if (key_down) pc_nxt = pc_r + ADDR_W'(2);
            end else if (kk == KK_SKNP) begin
              if (!key_down) pc_nxt = pc_r + ADDR_W'(2);
            end else begin
              status_nxt = ST_ILLEGAL;
              pc_nxt     = pc_r - ADDR_W'(2);
            end
          end
          default: begin
            case (kk)
              KK_LDDT: v_nxt[fx] = dt_r;
              KK_WKEY: begin
                if (rel_any) begin
                  v_nxt[fx] = {4'd0, rel_idx};
                end else begin
                  status_nxt = ST_WAIT_KEY;
                  pc_nxt     = pc_r - ADDR_W'(2);
                end
              end
              KK_SDT:  dt_nxt = vx_r;
              KK_SST:  st_nxt = vx_r;
              KK_ADDI: i_nxt = i_r + ADDR_W'(vx_r);
              KK_FONT: i_nxt = ADDR_W'({vx_r[3:0], 2'b00}) + ADDR_W'(vx_r[3:0]);
              KK_BCD:  state_nxt = S_BCD;
              KK_DUMP: state_nxt = S_ST;
              KK_FILL: state_nxt = S_LDA;
              default: begin
                status_nxt = ST_ILLEGAL;
                pc_nxt     = pc_r - ADDR_W'(2);
              end
            endcase
          end
        endcase
      end
      S_ROW: begin
        row_nxt   = scr_rdata_r;
        state_nxt = S_RESP;
      end
      S_CLS: begin
        scr_we = 1'b1;
        if (cnt_r[ROW_W-1:0] == ROW_W'(SCR_H - 1)) state_nxt = S_RESP;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_DRA: begin
        if (cnt_r[3:0] == fn || draw_row >= (ROW_W + 1)'(SCR_H)) begin
          v_nxt[15] = {7'd0, hit_r};
          drawn_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          mem_raddr = i_r + ADDR_W'(cnt_r[3:0]);
          scr_raddr = draw_row[ROW_W-1:0];
          state_nxt = S_DRB;
        end
      end
      S_DRB: begin
        hit_nxt   = hit_r | (|(scr_rdata_r & draw_mask));
        scr_we    = 1'b1;
        scr_waddr = draw_row[ROW_W-1:0];
        scr_wdata = scr_rdata_r ^ draw_mask;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DRA;
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = i_r + ADDR_W'(cnt_r[1:0]);
        mem_wdata = bcd_digit;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd2) state_nxt = S_RESP;
      end
      S_ST: begin
        mem_we    = 1'b1;
        mem_wdata = v_r[cnt_r[3:0]];
        i_nxt     = i_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[3:0] == fx) state_nxt = S_RESP;
      end
      S_LDA: begin
        mem_raddr = i_r;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        v_nxt[cnt_r[3:0]] = mem_rdata;
        i_nxt             = i_r + 1'b1;
        cnt_nxt           = cnt_r + 1'b1;
        state_nxt         = (cnt_r[3:0] == fx) ? S_RESP : S_LDA;
      end
      S_RESP: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) pc_nxt = cfg_pc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      pc_r     <= RESET_PC;
      i_r      <= '0;
      cnt_r    <= '0;
      sp_r     <= '0;
      dt_r     <= '0;
      st_r     <= '0;
      kn_r     <= '0;
      kb_r     <= '0;
      drawn_r  <= 1'b0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stk_r[k] <= '0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      i_r      <= i_nxt;
      cnt_r    <= cnt_nxt;
      sp_r     <= sp_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      kn_r     <= kn_nxt;
      kb_r     <= kb_nxt;
      drawn_r  <= drawn_nxt;
      v_r      <= v_nxt;
      stk_r    <= stk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    rnd_r    <= rnd_nxt;
    op_r     <= op_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    row_r    <= row_nxt;
  end

  assign ready      = (state_r == S_IDLE);
  assign res.status = status_r;
  assign res.pc     = pc_r;
  assign res.opcode = op_r;
  assign res.row    = row_r;
  assign res.sound  = (st_r != 8'd0);

endmodule

// File: rtl/chip8_instruction_core.sv
`timescale 1ns / 1ps
// Channel   Signals                                              Dir
// in        in_valid/in_ready, in_command..in_random_byte        in
// out       out_valid/out_ready, out_status..out_sound_on        out
// cfg       cfg_valid/cfg_ready, cfg_data (program start)        in
//
// After reset a sweep over every memory address loads the font and clears memory and screen;
// no transaction is taken meanwhile (cfg writes are).
// Frame and load finish in idle; row read adds a screen read; execute fetches two
// bytes; clear screen, sprite draw, BCD, register dump and fill add further states.
// One transaction at a time, set by the single memory read port and shared ALU;
// a held result stalls input until taken.
module chip8_instruction_core
  import c8core_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [7:0]           in_data_byte,
  input  logic [15:0]          in_keys,
  input  logic [7:0]           in_random_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_program_counter_out,
  output logic [15:0]          out_opcode,
  output logic [SCR_W-1:0]     out_display_row,
  output logic                 out_sound_on,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic       ctrl_ready, ctrl_done;
  c8_result_t ctrl_res, res_r;
  logic       out_valid_r;

  c8core_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid & in_ready),
    .cmd         (cmd_t'(in_command)),
    .address     (in_address),
    .data_byte   (in_data_byte),
    .keys        (in_keys),
    .random_byte (in_random_byte),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_pc      (cfg_data),
    .ready       (ctrl_ready),
    .done        (ctrl_done),
    .res         (ctrl_res)
  );

  assign in_ready  = ctrl_ready & ~out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_done) res_r <= ctrl_res;
  end

  assign out_valid               = out_valid_r;
  assign out_status              = res_r.status;
  assign out_program_counter_out = res_r.pc;
  assign out_opcode              = res_r.opcode;
  assign out_display_row         = res_r.row;
  assign out_sound_on            = res_r.sound;

endmodule

// File: rtl/c8core_checker.sv
`timescale 1ns / 1ps
module c8core_checker
  import c8core_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [15:0]       out_opcode
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_opcode))
    else $error("result changed while stalled");

  a_no_in_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_frame_wait_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_WAIT_FRAME |-> out_opcode == 16'd0)
    else $error("opcode reported while waiting for frame");

endmodule

bind chip8_instruction_core c8core_checker u_c8core_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_opcode (out_opcode)
);

// File: sim/tb_chip8_instruction_core.sv
`timescale 1ns / 1ps
module tb_chip8_instruction_core;
  import c8core_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_command;
  logic [ADDR_W-1:0] in_address;
  logic [7:0] in_data_byte;
  logic [15:0] in_keys;
  logic [7:0] in_random_byte;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [ADDR_W-1:0] out_program_counter_out;
  logic [15:0] out_opcode;
  logic [SCR_W-1:0] out_display_row;
  logic out_sound_on;
  logic cfg_valid, cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  chip8_instruction_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_address(in_address),
    .in_data_byte(in_data_byte), .in_keys(in_keys),
    .in_random_byte(in_random_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_program_counter_out(out_program_counter_out),
    .out_opcode(out_opcode), .out_display_row(out_display_row),
    .out_sound_on(out_sound_on),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [15:0]       keys;
    logic [7:0]        rnd;
  } c8_cmd_t;

  typedef struct {
    logic              known;
    status_t           status;
    logic [ADDR_W-1:0] pc;
    logic [15:0]       opcode;
  } c8_row_t;

  // shadow machine state
  logic [7:0]        mem_s [MEM_BYTES];
  logic [SCR_W-1:0]  scr_s [SCR_H];
  logic [7:0]        v_s [16];
  logic [ADDR_W-1:0] i_s, pc_s, start_s;
  logic [ADDR_W-1:0] stk_s [STACK_DEPTH];
  logic [SP_W-1:0]   sp_s;
  logic [7:0]        dt_s, st_s;
  logic [15:0]       keys_now_s, keys_prev_s;
  logic              drawn_s;

  c8_result_t results_due[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  bit stall_long = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("chip8_instruction_core regression: fail");
      $finish;
    end
  end

  task automatic shadow_reset();
    for (int a = 0; a < MEM_BYTES; a++) mem_s[a] = 8'd0;
    for (int a = 0; a < FONT_BYTES; a++) mem_s[a] = GLYPHS[a];
    for (int r = 0; r < SCR_H; r++) scr_s[r] = '0;
    for (int r = 0; r < 16; r++) begin
      v_s[r] = 8'd0;
      stk_s[r] = '0;
    end
    i_s = '0; pc_s = RESET_PC; start_s = RESET_PC; sp_s = '0;
    dt_s = 8'd0; st_s = 8'd0; keys_now_s = '0; keys_prev_s = '0; drawn_s = 0;
  endtask

  function automatic status_t run_opcode(logic [15:0] op, logic [7:0] rnd);
    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy, line;
    logic [ADDR_W-1:0] nnn;
    logic [8:0] sum;
    logic hit, down;
    int x0, y0;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    vx = v_s[x]; vy = v_s[y];
    case (op[15:12])
      4'h0: begin
        if (op == OP_CLS) for (int r = 0; r < SCR_H; r++) scr_s[r] = '0;
        else if (op == OP_RET) begin
          pc_s = stk_s[sp_s];
          sp_s = sp_s - 1'b1;
        end else pc_s = nnn;
      end
      4'h1: pc_s = nnn;
      4'h2: begin
        sp_s = sp_s + 1'b1;
        stk_s[sp_s] = pc_s;
        pc_s = nnn;
      end
      4'h3: if (vx == kk) pc_s = pc_s + ADDR_W'(2);
      4'h4: if (vx != kk) pc_s = pc_s + ADDR_W'(2);
      4'h5: begin
        if (n != 0) return ST_ILLEGAL;
        if (vx == vy) pc_s = pc_s + ADDR_W'(2);
      end
      4'h6: v_s[x] = kk;
      4'h7: v_s[x] = vx + kk;
      4'h8: begin
        case (n)
          4'h0: v_s[x] = vy;
          4'h1: begin v_s[x] = vx | vy; v_s[15] = 0; end
          4'h2: begin v_s[x] = vx & vy; v_s[15] = 0; end
          4'h3: begin v_s[x] = vx ^ vy; v_s[15] = 0; end
          4'h4: begin
            sum = vx + vy;
            v_s[x] = sum[7:0]; v_s[15] = {7'd0, sum[8]};
          end
          4'h5: begin v_s[x] = vx - vy; v_s[15] = {7'd0, vx >= vy}; end
          4'h6: begin v_s[x] = vy >> 1; v_s[15] = {7'd0, vy[0]}; end
          4'h7: begin v_s[x] = vy - vx; v_s[15] = {7'd0, vy >= vx}; end
          4'hE: begin v_s[x] = vy << 1; v_s[15] = {7'd0, vy[7]}; end
          default: return ST_ILLEGAL;
        endcase
      end
      4'h9: begin
        if (n != 0) return ST_ILLEGAL;
        if (vx != vy) pc_s = pc_s + ADDR_W'(2);
      end
      4'hA: i_s = nnn;
      4'hB: pc_s = nnn + ADDR_W'(v_s[0]);
      4'hC: v_s[x] = rnd & kk;
      4'hD: begin
        x0 = vx % SCR_W; y0 = vy % SCR_H; hit = 0;
        for (int r = 0; r < n && y0 + r < SCR_H; r++) begin
          line = mem_s[ADDR_W'(i_s + r)];
          for (int b = 0; b < 8 && x0 + b < SCR_W; b++)
            if (line[7-b]) begin
              if (scr_s[y0+r][63-x0-b]) hit = 1;
              scr_s[y0+r][63-x0-b] ^= 1'b1;
            end
        end
        v_s[15] = {7'd0, hit};
        drawn_s = 1;
      end
      4'hE: begin
        down = keys_now_s[vx[3:0]];
        if (kk == KK_SKP) begin if (down) pc_s = pc_s + ADDR_W'(2); end
        else if (kk == KK_SKNP) begin if (!down) pc_s = pc_s + ADDR_W'(2); end
        else return ST_ILLEGAL;
      end
      default: begin
        case (kk)
          KK_LDDT: v_s[x] = dt_s;
          KK_WKEY: begin
            for (int k = 0; k < 16; k++)
              if (keys_prev_s[k] && !keys_now_s[k]) begin
                v_s[x] = 8'(k);
                return ST_DONE;
              end
            pc_s = pc_s - ADDR_W'(2);
            return ST_WAIT_KEY;
          end
          KK_SDT: dt_s = vx;
          KK_SST: st_s = vx;
          KK_ADDI: i_s = i_s + ADDR_W'(vx);
          KK_FONT: i_s = ADDR_W'(vx[3:0]) * ADDR_W'(5);
          KK_BCD: begin
            mem_s[i_s] = vx / 8'd100;
            mem_s[ADDR_W'(i_s + 1)] = (vx / 8'd10) % 8'd10;
            mem_s[ADDR_W'(i_s + 2)] = vx % 8'd10;
          end
          KK_DUMP: for (int r = 0; r <= x; r++) begin
            mem_s[i_s] = v_s[r]; i_s = i_s + 1'b1;
          end
          KK_FILL: for (int r = 0; r <= x; r++) begin
            v_s[r] = mem_s[i_s]; i_s = i_s + 1'b1;
          end
          default: return ST_ILLEGAL;
        endcase
      end
    endcase
    return ST_DONE;
  endfunction

  function automatic c8_result_t step_core(c8_cmd_t c);
    c8_result_t res;
    res = '0;
    res.status = ST_DONE;
    case (c.cmd)
      CMD_EXEC: begin
        if (drawn_s) res.status = ST_WAIT_FRAME;
        else begin
          res.opcode = {mem_s[pc_s], mem_s[ADDR_W'(pc_s + 1)]};
          pc_s = pc_s + ADDR_W'(2);
          res.status = run_opcode(res.opcode, c.rnd);
          if (res.status == ST_ILLEGAL) pc_s = pc_s - ADDR_W'(2);
        end
      end
      CMD_FRAME: begin
        if (dt_s != 0) dt_s--;
        if (st_s != 0) st_s--;
        drawn_s = 0;
        keys_prev_s = keys_now_s;
        keys_now_s = c.keys;
      end
      CMD_LOAD: mem_s[c.addr] = c.data;
      default: res.row = scr_s[c.addr[4:0]];
    endcase
    res.pc = pc_s;
    res.sound = st_s != 0;
    return res;
  endfunction

  task automatic send_cmd(c8_cmd_t c);
    in_command = c.cmd; in_address = c.addr; in_data_byte = c.data;
    in_keys = c.keys; in_random_byte = c.rnd; in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(step_core(c));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic c8_cmd_t mk(cmd_t cmd, int addr, int data, int keys, int rnd);
    c8_cmd_t c;
    c.cmd = cmd; c.addr = ADDR_W'(addr); c.data = 8'(data);
    c.keys = 16'(keys); c.rnd = 8'(rnd);
    return c;
  endfunction

  task automatic load_word(int addr, logic [15:0] w);
    send_cmd(mk(CMD_LOAD, addr, w[15:8], 0, 0));
    send_cmd(mk(CMD_LOAD, addr + 1, w[7:0], 0, 0));
  endtask

  task automatic drain();
    while (results_due.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_start(logic [ADDR_W-1:0] a);
    cfg_data <= a; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    start_s = a; pc_s = a;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: checker
  always @(posedge clk) begin
    c8_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transaction");
      end else begin
        want = results_due.pop_front();
        if (out_status !== want.status || out_program_counter_out !== want.pc ||
            out_opcode !== want.opcode || out_display_row !== want.row ||
            out_sound_on !== want.sound) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch exp st=%0d pc=%h op=%h row=%h snd=%b got st=%0d pc=%h op=%h row=%h snd=%b",
                     want.status, want.pc, want.opcode, want.row, want.sound,
                     out_status, out_program_counter_out, out_opcode,
                     out_display_row, out_sound_on);
        end
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_long = 0;
      end
      out_ready <= ($urandom_range(0, 3) != 0) || cycles[9];
    end
  end

  // directed table
  c8_cmd_t dir_cmd [22];
  c8_row_t dir_exp [22];

  task automatic build_table();
    for (int k = 0; k < 22; k++) dir_exp[k].known = 0;
    dir_cmd[0] = mk(CMD_ROW, 0, 0, 0, 0);
    dir_exp[0] = '{1, ST_DONE, 12'h200, 16'h0};
    dir_cmd[1] = mk(CMD_ROW, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
    dir_cmd[2] = mk(CMD_EXEC, 0, 0, 0, 0);   // zero word: sys call to 0
    dir_exp[2] = '{1, ST_DONE, 12'h000, 16'h0000};
    dir_cmd[3] = mk(CMD_EXEC, 0, 0, 0, 0);   // font bytes F0 90: FX90 illegal
    dir_exp[3] = '{1, ST_ILLEGAL, 12'h000, 16'hF090};
    dir_cmd[4] = mk(CMD_FRAME, 0, 0, 16'hFFFF, 0);
    dir_cmd[5] = mk(CMD_FRAME, 0, 0, 16'h0000, 0);
    dir_cmd[6] = mk(CMD_LOAD, 12'hFFF, 8'hFF, 0, 0);
    dir_cmd[7] = mk(CMD_LOAD, 12'h000, 8'hF0, 0, 0);
    for (int k = 8; k < 22; k++) dir_cmd[k] = mk(CMD_EXEC, 0, 0, 0, 8'hA5);
  endtask

  // program for directed executes at 0x300
  logic [15:0] dir_prog [14] = '{
    16'h60FF, 16'h61FE, 16'h8014, 16'h8F17, 16'h8016, 16'h810E,
    16'hC3FF, 16'hF00A, 16'hF318, 16'hA000, 16'hD01F, 16'h00E0,
    16'h2300, 16'h00EE
  };

  task automatic rand_burst(int count, bit program_mode);
    c8_cmd_t c;
    int gap;
    for (int k = 0; k < count; k++) begin
      if (program_mode) begin
        case ($urandom_range(0, 9))
          0, 1: c = mk(CMD_FRAME, 0, 0, $urandom, 0);
          2: c = mk(CMD_ROW, $urandom, 0, 0, 0);
          3: c = mk(CMD_LOAD, $urandom_range(12'h300, 12'h33F), $urandom, 0, 0);
          default: c = mk(CMD_EXEC, $urandom, $urandom, $urandom, $urandom);
        endcase
      end else
        c = mk(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      if (!drawn_s && c.cmd == CMD_EXEC && $urandom_range(0, 5) == 0)
        c = mk(CMD_FRAME, 0, 0, $urandom, 0);
      send_cmd(c);
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 20);
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // write a random program, mostly well-formed opcodes, at 0x300
  task automatic load_program();
    logic [15:0] w;
    for (int a = 12'h300; a < 12'h340; a += 2) begin
      w = 16'($urandom);
      case ($urandom_range(0, 7))
        0: w[15:12] = 4'h8;
        1: w = {4'hF, w[11:8], 8'h33 + 8'h22 * 8'($urandom_range(0, 2))};
        2: w = {4'hA, 4'h3, w[7:0]};
        3: w = {4'h1, 12'h300 + 12'($urandom_range(0, 31) * 2)};
        4: w = {4'hE, w[11:8], ($urandom_range(0, 1) ? KK_SKP : KK_SKNP)};
        default: ;
      endcase
      load_word(a, w);
    end
  endtask

  initial begin
    c8_result_t r;
    rst_n = 1'b0;
    in_valid = 1'b0; in_command = '0; in_address = '0; in_data_byte = '0;
    in_keys = '0; in_random_byte = '0; cfg_valid = 1'b0; cfg_data = '0;
    shadow_reset();
    build_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 8; k++) begin
      send_cmd(dir_cmd[k]);
      if (dir_exp[k].known) begin
        r = results_due[$];
        if (r.status != dir_exp[k].status || r.pc != dir_exp[k].pc ||
            r.opcode != dir_exp[k].opcode) begin
          errors++;
          $display("directed row %0d disagrees with table", k);
        end
      end
    end
    drain();
    write_start(12'h300);
    for (int k = 0; k < 14; k++) load_word(12'h300 + 2 * k, dir_prog[k]);
    for (int k = 8; k < 22; k++) begin
      send_cmd(dir_cmd[k]);
      if (drawn_s) send_cmd(mk(CMD_FRAME, 0, 0, 16'h8001, 0));
      if (results_due[$].status == ST_WAIT_KEY)
        send_cmd(mk(CMD_FRAME, 0, 0, 16'h0000, 0));
    end
    send_cmd(mk(CMD_ROW, 0, 0, 0, 0));

    // long receiver hold-off while input keeps coming
    stall_long = 1;
    rand_burst(20, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_start(12'hFFF);
        1: write_start(12'h000);
        default: write_start(12'h300);
      endcase
      if (phase >= 2) load_program();
      rand_burst(phase < 2 ? 60 : 100, phase >= 2);
      drain();
    end

    if (errors == 0 && results_due.size() == 0)
      $display("chip8_instruction_core regression: pass");
    else
      $display("chip8_instruction_core regression: fail");
    $finish;
  end

endmodule
